// ===== sv/klam_pkg.sv =====
// Shared types, constants and codes for the knob low-pass angle mapper.
package klam_pkg;

    // Field widths fixed by the item formats.
    localparam int SAMPLE_BITS     = 12;
    localparam int ANGLE_FRAC_BITS = 8;
    localparam int DEG_BITS        = 9;
    localparam int ANGLE_BITS      = DEG_BITS + ANGLE_FRAC_BITS;
    localparam int SAMPLE_MAX      = (1 << SAMPLE_BITS) - 1;

    // Default number of filtered channels.
    localparam int CHANNELS_DEFAULT = 2;

    // Mapping constants: dead band at each end and minimum usable span.
    localparam int TRIM_COUNTS     = 40;
    localparam int MIN_SPAN_COUNTS = 100;
    localparam int CAL_SLACK       = 2 * TRIM_COUNTS + MIN_SPAN_COUNTS;

    // Configuration port.
    localparam int CFG_INDEX_BITS = 3;
    localparam int CFG_DATA_BITS  = SAMPLE_BITS;

    localparam logic [CFG_INDEX_BITS-1:0] REG_PAN_CAL_LOW   = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_PAN_CAL_HIGH  = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TILT_CAL_LOW  = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] REG_TILT_CAL_HIGH = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_FLOOR   = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] REG_ANGLE_CEILING = 3'd5;

    localparam logic [SAMPLE_BITS-1:0] CAL_LOW_RESET  = SAMPLE_BITS'(0);
    localparam logic [SAMPLE_BITS-1:0] CAL_HIGH_RESET = SAMPLE_BITS'(SAMPLE_MAX);
    localparam logic [DEG_BITS-1:0]    FLOOR_RESET    = DEG_BITS'(0);
    localparam logic [DEG_BITS-1:0]    CEILING_RESET  = DEG_BITS'(180);

    // Job classes decided by the front end.
    localparam int MODE_BITS = 2;
    localparam logic [MODE_BITS-1:0] MODE_SCALE = 2'd0;
    localparam logic [MODE_BITS-1:0] MODE_FLOOR = 2'd1;
    localparam logic [MODE_BITS-1:0] MODE_CEIL  = 2'd2;

    // Divider sizing: product of offset and angle range, two quotient bits per cycle.
    localparam int PROD_BITS      = SAMPLE_BITS + ANGLE_BITS;
    localparam int DIV_BITS_CYCLE = 2;
    localparam int DVD_BITS       = ((PROD_BITS + DIV_BITS_CYCLE - 1) / DIV_BITS_CYCLE)
                                    * DIV_BITS_CYCLE;
    localparam int DIV_CYCLES     = DVD_BITS / DIV_BITS_CYCLE;
    localparam int DIV_CNT_BITS   = $clog2(DIV_CYCLES + 1);

    // Job queue between front and back.
    localparam int QUEUE_DEPTH = 2;

    typedef struct packed {
        logic                   channel;
        logic [SAMPLE_BITS-1:0] sample;
    } klam_in_t;

    typedef struct packed {
        logic                   channel_out;
        logic [SAMPLE_BITS-1:0] filtered;
        logic [ANGLE_BITS-1:0]  angle_q8;
    } klam_out_t;

    typedef struct packed {
        logic                   channel;
        logic [SAMPLE_BITS-1:0] filtered;
        logic [MODE_BITS-1:0]   mode;
        logic [SAMPLE_BITS-1:0] num;
        logic [SAMPLE_BITS-1:0] den;
        logic [ANGLE_BITS-1:0]  range;
        logic [ANGLE_BITS-1:0]  amin;
        logic [ANGLE_BITS-1:0]  amax;
    } klam_job_t;

    typedef struct packed {
        logic full;
        logic empty;
    } klam_qstat_t;

endpackage

// ===== sv/klam_front.sv =====
// Front end: configuration registers, per-channel low-pass filter and job classification.
module klam_front #(
    parameter int CHANNELS = klam_pkg::CHANNELS_DEFAULT
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_valid,
    input  logic [klam_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [klam_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                 in_valid,
    output logic                                 in_ready,
    input  klam_pkg::klam_in_t                   in_data,
    input  klam_pkg::klam_qstat_t                qstat,
    output logic                                 push,
    output klam_pkg::klam_job_t                  push_job
);

    localparam int SB    = klam_pkg::SAMPLE_BITS;
    localparam int AB    = klam_pkg::ANGLE_BITS;
    localparam int CH_W  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int SUM_W = SB + 2;
    localparam int CW    = SB + 1;
    localparam int DW    = SB + 2;

    logic [SB-1:0]                    pan_lo_reg;
    logic [SB-1:0]                    pan_hi_reg;
    logic [SB-1:0]                    tilt_lo_reg;
    logic [SB-1:0]                    tilt_hi_reg;
    logic [klam_pkg::DEG_BITS-1:0]    floor_reg;
    logic [klam_pkg::DEG_BITS-1:0]    ceil_reg;
    logic [SB-1:0]                    filt_reg [CHANNELS];

    logic [CH_W-1:0]  ch_idx;
    logic [SB-1:0]    filt_old;
    logic [SUM_W-1:0] filt_sum;
    logic [SB-1:0]    filt_next;
    logic [SB-1:0]    cal_lo;
    logic [SB-1:0]    cal_hi;
    logic             cal_bad;
    logic [CW-1:0]    lo;
    logic [SB-1:0]    den;
    logic [DW-1:0]    offset;
    logic             offset_le_zero;
    logic [AB-1:0]    amin;
    logic [AB-1:0]    amax;

    assign in_ready = !qstat.full;
    assign push     = in_valid && in_ready;

    // Out-of-range channels fold onto the last one.
    assign ch_idx = (int'(in_data.channel) >= CHANNELS) ? CH_W'(CHANNELS - 1)
                                                         : CH_W'(in_data.channel);

    // Low-pass update: (sample + 3 * old + 2) / 4.
    assign filt_old  = filt_reg[ch_idx];
    assign filt_sum  = SUM_W'(in_data.sample) + SUM_W'(filt_old) + SUM_W'({filt_old, 1'b0})
                       + SUM_W'(2);
    assign filt_next = filt_sum[SUM_W-1:2];

    // Channel zero uses the pan calibration, all others the tilt calibration.
    assign cal_lo = (ch_idx == CH_W'(0)) ? pan_lo_reg : tilt_lo_reg;
    assign cal_hi = (ch_idx == CH_W'(0)) ? pan_hi_reg : tilt_hi_reg;

    // A span too narrow after trimming falls back to the full converter range.
    assign cal_bad = CW'(cal_hi) <= (CW'(cal_lo) + CW'(klam_pkg::CAL_SLACK));
    assign lo      = cal_bad ? CW'(0) : (CW'(cal_lo) + CW'(klam_pkg::TRIM_COUNTS));
    assign den     = cal_bad ? SB'(klam_pkg::SAMPLE_MAX)
                             : SB'(cal_hi - cal_lo - SB'(2 * klam_pkg::TRIM_COUNTS));

    assign offset         = DW'(filt_next) - DW'(lo);
    assign offset_le_zero = offset[DW-1] || (offset == DW'(0));

    assign amin = {floor_reg, klam_pkg::ANGLE_FRAC_BITS'(0)};
    assign amax = {ceil_reg, klam_pkg::ANGLE_FRAC_BITS'(0)};

    // Build the job; the clamp to the ceiling wins over everything else.
    always_comb
    begin
        push_job.channel  = ch_idx[0];
        push_job.filtered = filt_next;
        push_job.num      = offset[SB-1:0];
        push_job.den      = den;
        push_job.range    = amax - amin;
        push_job.amin     = amin;
        push_job.amax     = amax;
        priority if (ceil_reg < floor_reg)
        begin
            push_job.mode = klam_pkg::MODE_CEIL;
        end
        else if (offset_le_zero)
        begin
            push_job.mode = klam_pkg::MODE_FLOOR;
        end
        else
        begin
            push_job.mode = klam_pkg::MODE_SCALE;
        end
    end

    // Configuration registers; the write channel is always ready.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pan_lo_reg  <= klam_pkg::CAL_LOW_RESET;
            pan_hi_reg  <= klam_pkg::CAL_HIGH_RESET;
            tilt_lo_reg <= klam_pkg::CAL_LOW_RESET;
            tilt_hi_reg <= klam_pkg::CAL_HIGH_RESET;
            floor_reg   <= klam_pkg::FLOOR_RESET;
            ceil_reg    <= klam_pkg::CEILING_RESET;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                klam_pkg::REG_PAN_CAL_LOW:   pan_lo_reg  <= cfg_data[SB-1:0];
                klam_pkg::REG_PAN_CAL_HIGH:  pan_hi_reg  <= cfg_data[SB-1:0];
                klam_pkg::REG_TILT_CAL_LOW:  tilt_lo_reg <= cfg_data[SB-1:0];
                klam_pkg::REG_TILT_CAL_HIGH: tilt_hi_reg <= cfg_data[SB-1:0];
                klam_pkg::REG_ANGLE_FLOOR:   floor_reg   <= cfg_data[klam_pkg::DEG_BITS-1:0];
                klam_pkg::REG_ANGLE_CEILING: ceil_reg    <= cfg_data[klam_pkg::DEG_BITS-1:0];
                default:
                begin
                end
            endcase
        end
    end

    // Filter state, one value per channel, updated on every input transfer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < CHANNELS; i++)
            begin
                filt_reg[i] <= SB'(0);
            end
        end
        else if (push)
        begin
            filt_reg[ch_idx] <= filt_next;
        end
    end

endmodule

// ===== sv/klam_queue.sv =====
// Short job queue that decouples the front end from the divider back end.
module klam_queue (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  push,
    input  klam_pkg::klam_job_t   push_job,
    input  logic                  pop,
    output klam_pkg::klam_job_t   head,
    output klam_pkg::klam_qstat_t qstat
);

    localparam int DEPTH = klam_pkg::QUEUE_DEPTH;
    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    klam_pkg::klam_job_t slot_reg [DEPTH];
    logic [PTR_W-1:0]    wr_ptr_reg;
    logic [PTR_W-1:0]    wr_ptr_next;
    logic [PTR_W-1:0]    rd_ptr_reg;
    logic [PTR_W-1:0]    rd_ptr_next;
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    count_next;

    assign head        = slot_reg[rd_ptr_reg];
    assign qstat.full  = (count_reg == CNT_W'(DEPTH));
    assign qstat.empty = (count_reg == CNT_W'(0));

    // Pointer and fill count bookkeeping.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? PTR_W'(0) : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= PTR_W'(0);
            rd_ptr_reg <= PTR_W'(0);
            count_reg  <= CNT_W'(0);
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    // Job storage needs no reset.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// ===== sv/klam_back.sv =====
// Back end: multiplies, divides two quotient bits per cycle, offsets, clamps and holds the result.
module klam_back (
    input  logic                  clk,
    input  logic                  rst_n,
    input  klam_pkg::klam_job_t   head,
    input  klam_pkg::klam_qstat_t qstat,
    output logic                  pop,
    output logic                  out_valid,
    input  logic                  out_ready,
    output klam_pkg::klam_out_t   out_data
);

    localparam int SB   = klam_pkg::SAMPLE_BITS;
    localparam int AB   = klam_pkg::ANGLE_BITS;
    localparam int DVB  = klam_pkg::DVD_BITS;
    localparam int PB   = klam_pkg::PROD_BITS;
    localparam int CNTB = klam_pkg::DIV_CNT_BITS;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_DONE = 2'd2;

    logic [1:0]          state_reg;
    logic [1:0]          state_next;
    klam_pkg::klam_job_t job_reg;
    klam_pkg::klam_job_t job_next;
    logic [DVB-1:0]      dq_reg;
    logic [DVB-1:0]      dq_next;
    logic [SB-1:0]       rem_reg;
    logic [SB-1:0]       rem_next;
    logic [CNTB-1:0]     cnt_reg;
    logic [CNTB-1:0]     cnt_next;
    logic                out_valid_reg;
    logic                out_valid_next;
    klam_pkg::klam_out_t out_data_reg;
    klam_pkg::klam_out_t out_data_next;

    logic [DVB-1:0] step_dq;
    logic [SB-1:0]  step_rem;
    logic [DVB:0]   scaled_sum;
    logic [AB-1:0]  angle;
    logic           out_free;

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_free  = !out_valid_reg || out_ready;
    assign pop       = (state_reg == ST_IDLE) && !qstat.empty;

    // Restoring division, several quotient bits per cycle; dq holds dividend then quotient.
    always_comb
    begin
        logic [SB:0] trial;
        step_dq  = dq_reg;
        step_rem = rem_reg;
        for (int i = 0; i < klam_pkg::DIV_BITS_CYCLE; i++)
        begin
            trial   = {step_rem, step_dq[DVB-1]};
            step_dq = {step_dq[DVB-2:0], 1'b0};
            if (trial >= {1'b0, job_reg.den})
            begin
                step_rem   = SB'(trial - {1'b0, job_reg.den});
                step_dq[0] = 1'b1;
            end
            else
            begin
                step_rem = trial[SB-1:0];
            end
        end
    end

    // Add the floor to the quotient and clamp at the ceiling.
    assign scaled_sum = (DVB + 1)'(dq_reg) + (DVB + 1)'(job_reg.amin);

    always_comb
    begin
        unique case (job_reg.mode)
            klam_pkg::MODE_SCALE:
            begin
                angle = (scaled_sum > (DVB + 1)'(job_reg.amax)) ? job_reg.amax
                                                                : scaled_sum[AB-1:0];
            end
            klam_pkg::MODE_CEIL:  angle = job_reg.amax;
            klam_pkg::MODE_FLOOR: angle = job_reg.amin;
            default:              angle = job_reg.amin;
        endcase
    end

    // Sequencer: take a job, run the divider if it scales, then hand off the result.
    always_comb
    begin
        state_next     = state_reg;
        job_next       = job_reg;
        dq_next        = dq_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg && !out_ready;
        out_data_next  = out_data_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    job_next   = head;
                    dq_next    = DVB'(PB'(head.num) * PB'(head.range));
                    rem_next   = SB'(0);
                    cnt_next   = CNTB'(klam_pkg::DIV_CYCLES);
                    state_next = (head.mode == klam_pkg::MODE_SCALE) ? ST_DIV : ST_DONE;
                end
            end
            ST_DIV:
            begin
                dq_next  = step_dq;
                rem_next = step_rem;
                cnt_next = cnt_reg - CNTB'(1);
                if (cnt_reg == CNTB'(1))
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_data_next.channel_out = job_reg.channel;
                    out_data_next.filtered    = job_reg.filtered;
                    out_data_next.angle_q8    = angle;
                    state_next                = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= CNTB'(0);
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Datapath registers need no reset.
    always_ff @(posedge clk)
    begin
        job_reg      <= job_next;
        dq_reg       <= dq_next;
        rem_reg      <= rem_next;
        out_data_reg <= out_data_next;
    end

    // Only scaling jobs run through the divider.
    a_div_only_scale: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_DIV) |-> (job_reg.mode == klam_pkg::MODE_SCALE))
        else $error("divider running on a job that does not scale");

    // A finished division leaves a remainder below the divisor.
    a_rem_below_den: assert property (@(posedge clk) disable iff (!rst_n)
        ((state_reg == ST_DONE) && (job_reg.mode == klam_pkg::MODE_SCALE))
        |-> (rem_reg < job_reg.den))
        else $error("division remainder not below divisor");

    // A job taken from the queue always leaves the idle state.
    a_pop_starts_job: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> (state_reg != ST_IDLE))
        else $error("job popped but sequencer stayed idle");

endmodule

// ===== sv/knob_lowpass_angle_map_top.sv =====
// Top level of the knob low-pass filter and angle mapper.
//
//  Port group  Direction  Handshake              Carries
//  cfg_*       in         cfg_valid / cfg_ready  register index and write data
//  in_*        in         in_valid / in_ready    channel and raw sample
//  out_*       out        out_valid / out_ready  channel, filtered reading, Q9.8 angle
//
// An item that needs scaling passes in the back end from the idle state through
// the divider state, where the divider retires two quotient bits a cycle, to the
// done state; an item clamped to the floor or ceiling goes straight to done.
// The filter updates in the cycle of the input transfer, and a two-entry job
// queue lets the input side keep accepting while the divider or the output stalls.
// Reset is asynchronous and active low; it clears the filter state and loads
// the register defaults. Configuration writes are always accepted.
module knob_lowpass_angle_map_top #(
    parameter int CHANNELS = klam_pkg::CHANNELS_DEFAULT
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                cfg_valid,
    output logic                                cfg_ready,
    input  logic [klam_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [klam_pkg::CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  klam_pkg::klam_in_t                  in_data,
    output logic                                out_valid,
    input  logic                                out_ready,
    output klam_pkg::klam_out_t                 out_data
);

    klam_pkg::klam_job_t   push_job;
    klam_pkg::klam_job_t   head;
    klam_pkg::klam_qstat_t qstat;
    logic                  push;
    logic                  pop;

    assign cfg_ready = 1'b1;

    klam_front #(
        .CHANNELS (CHANNELS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .qstat     (qstat),
        .push      (push),
        .push_job  (push_job)
    );

    klam_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .qstat    (qstat)
    );

    klam_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .qstat     (qstat),
        .pop       (pop),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

endmodule

// ===== tb/knob_lowpass_angle_map_checker.sv =====
// Checker that predicts and compares every reading of the knob low-pass angle mapper.
module knob_lowpass_angle_map_checker
    import klam_pkg::*;
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_valid,
    input  logic                      cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [CFG_DATA_BITS-1:0]  cfg_data,
    input  logic                      in_valid,
    input  logic                      in_ready,
    input  klam_in_t                  in_data,
    input  logic                      out_valid,
    input  logic                      out_ready,
    input  klam_out_t                 out_data,
    output int                        mismatch_count,
    output int                        readings_due,
    output int                        readings_checked,
    output int                        clamp_hits
);

    // Shadow copy of the filter state and the register file.
    logic [SAMPLE_BITS-1:0] knob_filter [CHANNELS_DEFAULT];
    logic [SAMPLE_BITS-1:0] cal_lo [2];
    logic [SAMPLE_BITS-1:0] cal_hi [2];
    logic [DEG_BITS-1:0]    floor_deg;
    logic [DEG_BITS-1:0]    ceiling_deg;

    // Readings predicted from accepted samples, oldest first.
    klam_out_t due_readings [$];

    // Map a filtered value onto the calibrated travel as a clamped Q9.8 angle.
    function automatic logic [ANGLE_BITS-1:0] travel_angle(input logic [SAMPLE_BITS-1:0] filt,
                                                           input logic sel);
        longint lo;
        longint hi;
        longint amin;
        longint amax;
        longint a;
        lo   = longint'(cal_lo[sel]) + TRIM_COUNTS;
        hi   = longint'(cal_hi[sel]) - TRIM_COUNTS;
        amin = longint'(floor_deg) << ANGLE_FRAC_BITS;
        amax = longint'(ceiling_deg) << ANGLE_FRAC_BITS;
        // An inverted angle range always lands on the ceiling.
        if (ceiling_deg < floor_deg)
            return amax[ANGLE_BITS-1:0];
        // Too little calibrated span: fall back to the full converter range.
        if (hi <= lo + MIN_SPAN_COUNTS)
        begin
            lo = 0;
            hi = SAMPLE_MAX;
        end
        a = (longint'(filt) - lo) * (amax - amin) / (hi - lo) + amin;
        if (a < amin)
            a = amin;
        if (a > amax)
            a = amax;
        return a[ANGLE_BITS-1:0];
    endfunction

    // Update the channel's filter and build the reading it produces.
    function automatic klam_out_t next_reading(input klam_in_t item);
        klam_out_t r;
        int        acc;
        acc = int'(item.sample) + 3 * int'(knob_filter[item.channel]) + 2;
        knob_filter[item.channel] = SAMPLE_BITS'(acc >> 2);
        r.channel_out = item.channel;
        r.filtered    = knob_filter[item.channel];
        r.angle_q8    = travel_angle(r.filtered, item.channel);
        return r;
    endfunction

    // Follow register writes, check readings, then queue predictions.
    always @(posedge clk or negedge rst_n)
    begin
        klam_out_t want;
        logic      bad;
        if (!rst_n)
        begin
            knob_filter[0] = '0;
            knob_filter[1] = '0;
            cal_lo[0]      = CAL_LOW_RESET;
            cal_lo[1]      = CAL_LOW_RESET;
            cal_hi[0]      = CAL_HIGH_RESET;
            cal_hi[1]      = CAL_HIGH_RESET;
            floor_deg      = FLOOR_RESET;
            ceiling_deg    = CEILING_RESET;
            due_readings.delete();
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PAN_CAL_LOW:   cal_lo[0]   = cfg_data[SAMPLE_BITS-1:0];
                    REG_PAN_CAL_HIGH:  cal_hi[0]   = cfg_data[SAMPLE_BITS-1:0];
                    REG_TILT_CAL_LOW:  cal_lo[1]   = cfg_data[SAMPLE_BITS-1:0];
                    REG_TILT_CAL_HIGH: cal_hi[1]   = cfg_data[SAMPLE_BITS-1:0];
                    REG_ANGLE_FLOOR:   floor_deg   = cfg_data[DEG_BITS-1:0];
                    REG_ANGLE_CEILING: ceiling_deg = cfg_data[DEG_BITS-1:0];
                    default: ;
                endcase
            end

            // A reading can never belong to the sample accepted at the same edge.
            if (out_valid && out_ready)
            begin
                if (due_readings.size() == 0)
                begin
                    $display("%0t: unexpected reading: channel %0d filtered %0d angle %0d",
                             $time, out_data.channel_out, out_data.filtered, out_data.angle_q8);
                    mismatch_count++;
                end
                else
                begin
                    want = due_readings.pop_front();
                    bad  = 1'b0;
                    if (out_data.channel_out !== want.channel_out)
                    begin
                        $display("%0t: channel mismatch: expected %0d, actual %0d",
                                 $time, want.channel_out, out_data.channel_out);
                        bad = 1'b1;
                    end
                    if (out_data.filtered !== want.filtered)
                    begin
                        $display("%0t: filtered mismatch on channel %0d: expected %0d, actual %0d",
                                 $time, want.channel_out, want.filtered, out_data.filtered);
                        bad = 1'b1;
                    end
                    if (out_data.angle_q8 !== want.angle_q8)
                    begin
                        $display("%0t: angle mismatch on channel %0d: expected %0d, actual %0d",
                                 $time, want.channel_out, want.angle_q8, out_data.angle_q8);
                        bad = 1'b1;
                    end
                    if (bad)
                        mismatch_count++;
                    readings_checked++;
                end
            end

            if (in_valid && in_ready)
            begin
                want = next_reading(in_data);
                if (want.angle_q8 == {floor_deg, {ANGLE_FRAC_BITS{1'b0}}} ||
                    want.angle_q8 == {ceiling_deg, {ANGLE_FRAC_BITS{1'b0}}})
                    clamp_hits++;
                due_readings.push_back(want);
            end
        end
        readings_due = due_readings.size();
    end

endmodule

// ===== tb/knob_lowpass_angle_map_top_tb.sv =====
// Testbench top for the knob low-pass angle mapper: stimulus, flow control and verdict.
module knob_lowpass_angle_map_top_tb;
    import klam_pkg::*;

    // Spare register indexes that the block must ignore.
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_A = REG_ANGLE_CEILING + 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_B = REG_ANGLE_CEILING + 3'd2;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 128;
    localparam int BURST_ITEMS     = 16;
    localparam int HOLD_CYCLES     = 400;
    localparam int SETTLE_CYCLES   = 40;
    localparam int IDLE_LIMIT      = 5000;

    logic                      clk;
    logic                      rst_n;
    logic                      cfg_valid;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;
    logic                      in_valid;
    logic                      in_ready;
    klam_in_t                  in_data;
    logic                      out_valid;
    logic                      out_ready;
    klam_out_t                 out_data;

    int mismatch_count;
    int readings_due;
    int readings_checked;
    int clamp_hits;

    int samples_sent;
    int settings_used;
    int hold_request;
    int stall_left;
    int quiet_cycles;
    bit idle_off;

    knob_lowpass_angle_map_top u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_data   (in_data),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_data  (out_data)
    );

    knob_lowpass_angle_map_checker u_checker (
        .clk              (clk),
        .rst_n            (rst_n),
        .cfg_valid        (cfg_valid),
        .cfg_ready        (cfg_ready),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .in_valid         (in_valid),
        .in_ready         (in_ready),
        .in_data          (in_data),
        .out_valid        (out_valid),
        .out_ready        (out_ready),
        .out_data         (out_data),
        .mismatch_count   (mismatch_count),
        .readings_due     (readings_due),
        .readings_checked (readings_checked),
        .clamp_hits       (clamp_hits)
    );

    // Clock with a period of 10.
    initial
        clk = 1'b0;
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Reading consumer: random stalls, plus one long hold-off on request.
    always @(posedge clk)
    begin
        int roll;
        if (!rst_n)
            out_ready <= 1'b0;
        else if (stall_left > 0)
        begin
            out_ready  <= 1'b0;
            stall_left <= stall_left - 1;
        end
        else if (hold_request > 0)
        begin
            out_ready    <= 1'b0;
            stall_left   <= hold_request - 1;
            hold_request = 0;
        end
        else if (idle_off)
            out_ready <= 1'b1;
        else
        begin
            roll = $urandom_range(0, 99);
            if (roll < 10)
            begin
                out_ready  <= 1'b0;
                stall_left <= (roll == 0) ? $urandom_range(20, 80) : $urandom_range(0, 2);
            end
            else
                out_ready <= 1'b1;
        end
    end

    // Watchdog: too long without any transfer ends the run.
    always @(posedge clk)
    begin
        if (!rst_n || (cfg_valid && cfg_ready) || (in_valid && in_ready) ||
            (out_valid && out_ready))
            quiet_cycles <= 0;
        else if (quiet_cycles >= IDLE_LIMIT)
        begin
            $display("%0t: no transfer for %0d cycles, giving up", $time, IDLE_LIMIT);
            $display("RESULT: ERROR");
            $finish;
        end
        else
            quiet_cycles <= quiet_cycles + 1;
    end

    // Gap before the next sample: mostly none or short, sometimes long.
    function automatic int pick_gap();
        int roll;
        if (idle_off)
            return 0;
        roll = $urandom_range(0, 99);
        if (roll < 60)
            return 0;
        if (roll < 92)
            return $urandom_range(1, 3);
        if (roll < 98)
            return $urandom_range(4, 12);
        return $urandom_range(30, 120);
    endfunction

    // One register write transfer.
    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        @(posedge clk);
    endtask

    // One sample transfer; valid stays high when the next sample follows at once.
    task automatic push_sample(input klam_in_t item, input int gap);
        if (gap > 0)
        begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= item;
        do
            @(posedge clk);
        while (!in_ready);
        samples_sent++;
    endtask

    // Stop offering samples and wait until every predicted reading has arrived.
    task automatic wait_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (readings_due != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Load one register setting: random by default, fixed corners in the first phases.
    task automatic program_phase(input int p);
        logic [CFG_DATA_BITS-1:0] val [6];
        int lo;
        int hi;
        int fl;
        int cl;
        int pick;
        for (int c = 0; c < 2; c++)
        begin
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                lo = $urandom_range(2048, SAMPLE_MAX);
                hi = $urandom_range(0, 2047);
            end
            else if (pick == 1)
            begin
                // Spans around the fallback threshold.
                lo = $urandom_range(0, 3800);
                hi = lo + $urandom_range(170, 200);
            end
            else
            begin
                lo = $urandom_range(0, 1500);
                hi = $urandom_range(2500, SAMPLE_MAX);
            end
            val[REG_PAN_CAL_LOW + 2 * c]  = CFG_DATA_BITS'(lo);
            val[REG_PAN_CAL_HIGH + 2 * c] = CFG_DATA_BITS'(hi);
        end
        fl   = $urandom_range(0, 360);
        pick = $urandom_range(0, 9);
        if (pick == 0)
            cl = $urandom_range(0, fl);
        else if (pick == 1)
            cl = $urandom_range(361, 511);
        else
            cl = $urandom_range(fl, 360);
        // Upper data bits are random; the degree registers keep only nine bits.
        val[REG_ANGLE_FLOOR]   = {3'($urandom), 9'(fl)};
        val[REG_ANGLE_CEILING] = {3'($urandom), 9'(cl)};

        case (p)
            0:
            begin
                // Full converter travel, angle range of a full turn.
                val[REG_PAN_CAL_LOW]   = '0;
                val[REG_PAN_CAL_HIGH]  = CFG_DATA_BITS'(SAMPLE_MAX);
                val[REG_TILT_CAL_LOW]  = '0;
                val[REG_TILT_CAL_HIGH] = CFG_DATA_BITS'(SAMPLE_MAX);
                val[REG_ANGLE_FLOOR]   = '0;
                val[REG_ANGLE_CEILING] = CFG_DATA_BITS'(360);
            end
            1:
            begin
                // Inverted pan calibration, narrowest usable tilt span, zero angle range.
                val[REG_PAN_CAL_LOW]   = CFG_DATA_BITS'(SAMPLE_MAX);
                val[REG_PAN_CAL_HIGH]  = '0;
                val[REG_TILT_CAL_LOW]  = CFG_DATA_BITS'(1000);
                val[REG_TILT_CAL_HIGH] = CFG_DATA_BITS'(1000 + CAL_SLACK + 1);
                val[REG_ANGLE_FLOOR]   = CFG_DATA_BITS'(90);
                val[REG_ANGLE_CEILING] = CFG_DATA_BITS'(90);
            end
            2:
            begin
                // Span exactly at the threshold, equal ends, ceiling below floor.
                val[REG_PAN_CAL_LOW]   = CFG_DATA_BITS'(500);
                val[REG_PAN_CAL_HIGH]  = CFG_DATA_BITS'(500 + CAL_SLACK);
                val[REG_TILT_CAL_LOW]  = CFG_DATA_BITS'(2000);
                val[REG_TILT_CAL_HIGH] = CFG_DATA_BITS'(2000);
                val[REG_ANGLE_FLOOR]   = CFG_DATA_BITS'(360);
                val[REG_ANGLE_CEILING] = '0;
            end
            3:
            begin
                // Trim exactly at the ends, degrees at their nine-bit maximum.
                val[REG_PAN_CAL_LOW]   = CFG_DATA_BITS'(TRIM_COUNTS);
                val[REG_PAN_CAL_HIGH]  = CFG_DATA_BITS'(SAMPLE_MAX - TRIM_COUNTS);
                val[REG_ANGLE_FLOOR]   = '1;
                val[REG_ANGLE_CEILING] = '1;
            end
            4:
            begin
                // Floor masked to zero, ceiling beyond a full turn.
                val[REG_ANGLE_FLOOR]   = CFG_DATA_BITS'(12'hE00);
                val[REG_ANGLE_CEILING] = CFG_DATA_BITS'(12'h1FF);
            end
            default: ;
        endcase

        for (int r = REG_PAN_CAL_LOW; r <= REG_ANGLE_CEILING; r++)
            write_reg(CFG_INDEX_BITS'(r), val[r]);
        // Writes to unmapped indexes must change nothing.
        if (p == 4 || $urandom_range(0, 2) == 0)
        begin
            write_reg(REG_UNMAPPED_A, CFG_DATA_BITS'($urandom));
            write_reg(REG_UNMAPPED_B, CFG_DATA_BITS'($urandom));
        end
        settings_used++;
    endtask

    // Random samples: mostly runs that let the filter settle on a target, plus noise.
    task automatic drive_phase(input int count);
        klam_in_t item;
        int       sent;
        int       run;
        int       target;
        int       v;
        int       kind;
        logic     run_ch;
        sent = 0;
        while (sent < count)
        begin
            kind   = $urandom_range(0, 99);
            run_ch = 1'($urandom_range(0, 1));
            target = $urandom_range(0, SAMPLE_MAX);
            if (kind < 70)
                run = $urandom_range(4, 20);
            else if (kind < 85)
            begin
                // Long runs at a rail drive the filter into the clamps.
                run    = $urandom_range(16, 30);
                target = ($urandom_range(0, 1) != 0) ? SAMPLE_MAX : 0;
            end
            else
                run = 1;
            for (int k = 0; k < run && sent < count; k++)
            begin
                v = target;
                if (kind < 70)
                    v = target + int'($urandom_range(0, 30)) - 15;
                if (v < 0)
                    v = 0;
                if (v > SAMPLE_MAX)
                    v = SAMPLE_MAX;
                item.channel = run_ch;
                item.sample  = SAMPLE_BITS'(v);
                // Interleave stray samples on the other knob.
                if ($urandom_range(0, 4) == 0)
                begin
                    item.channel = ~run_ch;
                    item.sample  = SAMPLE_BITS'($urandom);
                end
                push_sample(item, pick_gap());
                sent++;
            end
        end
    endtask

    // Main stimulus sequence and verdict.
    initial
    begin
        klam_in_t item;
        rst_n        = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = '0;
        cfg_data     = '0;
        in_valid     = 1'b0;
        in_data      = '0;
        out_ready    = 1'b0;
        idle_off     = 1'b0;
        hold_request = 0;
        stall_left   = 0;
        quiet_cycles = 0;
        samples_sent = 0;
        settings_used = 1;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed samples at reset settings: rails, floor clamp, ceiling clamp, midscale.
        for (int i = 0; i < 25; i++)
        begin
            item.channel = 1'b0;
            item.sample  = SAMPLE_BITS'(SAMPLE_MAX);
            if (i == 0 || i == 24)
            begin
                item.channel = 1'b1;
                item.sample  = '0;
            end
            else if (i == 19 || i == 20)
                item.sample = '0;
            else if (i == 21)
                item.channel = 1'b1;
            else if (i == 22)
            begin
                item.channel = 1'b1;
                item.sample  = SAMPLE_BITS'(2048);
            end
            else if (i == 23)
                item.sample = SAMPLE_BITS'(1);
            push_sample(item, pick_gap());
        end
        wait_drained();

        for (int p = 0; p < PHASES; p++)
        begin
            program_phase(p);
            idle_off = (p % 4 == 2);
            if (p == 3)
            begin
                // Hold the reading side off while samples keep coming back to back.
                hold_request = HOLD_CYCLES;
                for (int b = 0; b < BURST_ITEMS; b++)
                begin
                    item.channel = 1'($urandom_range(0, 1));
                    item.sample  = SAMPLE_BITS'($urandom);
                    push_sample(item, 0);
                end
            end
            drive_phase(ITEMS_PER_PHASE);
            wait_drained();
        end
        idle_off = 1'b0;

        $display("Summary: %0d samples over %0d register settings, %0d readings checked.",
                 samples_sent, settings_used, readings_checked);
        $display("Summary: %0d readings at the floor or ceiling, %0d mismatching readings.",
                 clamp_hits, mismatch_count);
        if (mismatch_count == 0 && readings_due == 0)
        begin
            $display("RESULT: OK");
        end
        else
        begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/klam_pkg.sv
sv/klam_front.sv
sv/klam_queue.sv
sv/klam_back.sv
sv/knob_lowpass_angle_map_top.sv
tb/knob_lowpass_angle_map_checker.sv
tb/knob_lowpass_angle_map_top_tb.sv
